FILE: rtl/qlu_pkg.sv
`default_nettype none

package qlu_pkg;

	localparam int STATES  = 54432;
	localparam int STATE_W = 16;
	localparam int INDEX_W = 21;
	localparam int Q_W     = 32;
	localparam int RATE_W  = 16;
	localparam int CFG_W   = 2;

	// update datapath widths
	localparam int T_W = 35;
	localparam int P_W = 52;

	localparam logic [RATE_W-1:0] LEARNING_RATE_RST = 16'd6554;
	localparam logic [RATE_W-1:0] DISCOUNT_RST      = 16'd62259;

	localparam logic [CFG_W-1:0] REG_LEARNING_RATE = 2'd0;
	localparam logic [CFG_W-1:0] REG_DISCOUNT      = 2'd1;

	typedef enum logic [1:0] {
		CMD_LATCH  = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ALU_MUL_GAMMA = 2'd0,
		ALU_SUM       = 2'd1,
		ALU_MUL_ALPHA = 2'd2,
		ALU_FINAL     = 2'd3
	} alu_op_t;

	typedef struct packed {
		logic    en;
		alu_op_t op;
	} alu_ctrl_t;

	// threshold ladders, unused slots can never be exceeded
	localparam logic [7:0][15:0] HP_STEPS = {16'd89, 16'd69, 16'd49, 16'd29,
		16'd19, 16'd14, 16'd9, 16'd4};
	localparam logic [7:0][15:0] SCRAP_STEPS = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd40,
		16'd25, 16'd14, 16'd9, 16'd4};
	localparam logic [7:0][15:0] POWER_STEPS = {16'd94, 16'd84, 16'd74, 16'd64,
		16'd54, 16'd44, 16'd34, 16'd29};
	localparam logic [7:0][15:0] FUEL_STEPS = {16'hFFFF, 16'hFFFF, 16'd9, 16'd6,
		16'd4, 16'd2, 16'd1, 16'd0};
	localparam logic [7:0][15:0] STAGE_STEPS = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		16'hFFFF, 16'd19, 16'd14, 16'd9};
	localparam logic [7:0][15:0] BOMB_STEPS = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		16'hFFFF, 16'd2, 16'd1, 16'd0};

	function automatic logic [3:0] bucket_of(input logic [15:0] v,
		input logic [7:0][15:0] steps);
		logic [3:0] b;
		b = '0;
		for (int i = 0; i < 8; i++) begin
			if (v > steps[i]) begin
				b = b + 4'd1;
			end
		end
		return b;
	endfunction

	function automatic logic [STATE_W-1:0] state_of(input logic [7:0] hp,
		input logic [15:0] scrap, input logic [7:0] power, input logic [7:0] fuel,
		input logic [7:0] stage, input logic [7:0] bomb);
		logic [STATE_W-1:0] s;
		s = STATE_W'(bucket_of({8'd0, hp}, HP_STEPS));
		s = s * 16'd6 + STATE_W'(bucket_of(scrap, SCRAP_STEPS));
		s = s * 16'd9 + STATE_W'(bucket_of({8'd0, power}, POWER_STEPS));
		s = s * 16'd7 + STATE_W'(bucket_of({8'd0, fuel}, FUEL_STEPS));
		s = s * 16'd4 + STATE_W'(bucket_of({8'd0, stage}, STAGE_STEPS));
		s = s * 16'd4 + STATE_W'(bucket_of({8'd0, bomb}, BOMB_STEPS));
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/qlu_if.sv
`default_nettype none

interface qlu_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [7:0]         hp;
	logic [15:0]        scrap;
	logic [7:0]         power;
	logic [7:0]         fuel;
	logic [7:0]         stage;
	logic [7:0]         bomb;
	logic [2:0]         encounter;
	logic [1:0]         action;
	logic signed [31:0] reward;

	modport source (output valid, command, hp, scrap, power, fuel, stage, bomb,
		encounter, action, reward, input ready);
	modport sink (input valid, command, hp, scrap, power, fuel, stage, bomb,
		encounter, action, reward, output ready);
endinterface

interface qlu_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] q_value;
	logic [20:0]        entry_index;

	modport source (output valid, q_value, entry_index, input ready);
	modport sink (input valid, q_value, entry_index, output ready);
endinterface

interface qlu_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/qlu_ram.sv
`default_nettype none

module qlu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

FILE: rtl/qlu_alu.sv
`default_nettype none

module qlu_alu (
	input  logic               clk,
	input  qlu_pkg::alu_ctrl_t ctrl,
	input  logic [15:0]        alpha,
	input  logic [15:0]        gamma,
	input  logic signed [31:0] best,
	input  logic signed [31:0] cur,
	input  logic signed [31:0] reward,
	output logic signed [31:0] result
);

	import qlu_pkg::*;

	logic signed [16:0]    mul_a;
	logic signed [T_W-1:0] mul_b;
	logic signed [P_W-1:0] product;
	logic signed [P_W-1:0] diff;
	logic signed [P_W-1:0] wide;
	logic signed [36:0]    nv;
	logic signed [31:0]    sat;

	logic signed [P_W-1:0] prod_q;
	logic signed [T_W-1:0] t_q;
	logic signed [31:0]    result_q;

	// single shared multiplier: gamma*max, then alpha*t
	assign mul_a   = (ctrl.op == ALU_MUL_GAMMA) ? $signed({1'b0, gamma})
		: $signed({1'b0, alpha});
	assign mul_b   = (ctrl.op == ALU_MUL_GAMMA) ? T_W'(best) : t_q;
	assign product = P_W'(mul_a) * P_W'(mul_b);

	// t = floor(((r - q) * 2^16 + gamma*max) / 2^16)
	assign diff = P_W'(reward) - P_W'(cur);
	assign wide = (diff <<< 16) + prod_q;

	// new = q + floor(alpha*t / 2^16), saturated
	assign nv  = 37'(cur) + 37'($signed(prod_q[P_W-1:16]));
	assign sat = (nv[36:31] == {6{nv[36]}}) ? nv[31:0]
		: (nv[36] ? 32'sh80000000 : 32'sh7FFFFFFF);

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			unique case (ctrl.op)
				ALU_MUL_GAMMA, ALU_MUL_ALPHA: begin
					prod_q <= product;
				end
				ALU_SUM: begin
					t_q <= wide[T_W+15:16];
				end
				ALU_FINAL: begin
					result_q <= sat;
				end
			endcase
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

FILE: rtl/tabular_q_learning_update_unit.sv
`default_nettype none
// Command 0 only latches the held entry and reward and gives no response; command 2 reads
// one entry to the output register; command 1 needs one RAM read per action of the
// next row, one read of the held entry and two passes through the shared multiplier.
// One item in flight at a time; the output register frees the input for the next item.
// Reset: after arst_n the table is zeroed, one entry per cycle, all STATES * ENCOUNTERS *
// ACTIONS entries (1088640 by default); configuration writes are taken meanwhile.

module tabular_q_learning_update_unit #(
	parameter int ACTIONS    = 4,
	parameter int ENCOUNTERS = 5
) (
	input  logic     clk,
	input  logic     arst_n,
	qlu_req_if.sink  req,
	qlu_rsp_if.source rsp,
	qlu_cfg_if.sink  cfg
);

	import qlu_pkg::*;

	localparam int TABLE_SIZE = STATES * ENCOUNTERS * ACTIONS;
	localparam int ADDR_W     = $clog2(TABLE_SIZE);
	localparam int ACT_W      = $clog2(ACTIONS);

	typedef enum logic [12:0] {
		S_CLEAR  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_BASE   = 13'b0000000000100,
		S_ROW    = 13'b0000000001000,
		S_CUR    = 13'b0000000010000,
		S_CUR_W  = 13'b0000000100000,
		S_SUM    = 13'b0000001000000,
		S_MUL_A  = 13'b0000010000000,
		S_FINAL  = 13'b0000100000000,
		S_WRITE  = 13'b0001000000000,
		S_READ   = 13'b0010000000000,
		S_READ_W = 13'b0100000000000,
		S_DONE   = 13'b1000000000000
	} state_t;

	state_t state_q;

	logic [RATE_W-1:0]  alpha_q;
	logic [RATE_W-1:0]  gamma_q;
	logic [INDEX_W-1:0] held_entry_q;
	logic signed [31:0] held_reward_q;

	logic [STATE_W-1:0] s_q;
	logic [2:0]         enc_q;
	logic [1:0]         act_q;
	cmd_t               cmd_q;
	logic signed [31:0] rwd_q;
	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [ACT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  clr_q;
	logic               first_q;
	logic               row_rd_s1;
	logic signed [31:0] best_q;
	logic signed [31:0] cur_q;
	logic signed [31:0] res_val_q;
	logic [INDEX_W-1:0] res_idx_q;

	logic               out_valid_q;
	logic signed [31:0] out_val_q;
	logic [INDEX_W-1:0] out_idx_q;

	logic [ADDR_W-1:0]  base_c;
	logic [ADDR_W-1:0]  idx_c;
	logic               item_ok;
	logic               accept;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [Q_W-1:0]     ram_wdata;
	logic [Q_W-1:0]     ram_rdata;

	alu_ctrl_t          alu_ctrl;
	logic signed [31:0] alu_result;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= LEARNING_RATE_RST;
			gamma_q <= DISCOUNT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LEARNING_RATE: alpha_q <= cfg.data;
				REG_DISCOUNT:      gamma_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign item_ok = (req.command == CMD_LATCH || req.command == CMD_UPDATE
		|| req.command == CMD_READ)
		&& (32'(req.encounter) < 32'(ENCOUNTERS))
		&& (32'(req.action) < 32'(ACTIONS));

	assign base_c = (ADDR_W'(s_q) * ADDR_W'(ENCOUNTERS) + ADDR_W'(enc_q))
		* ADDR_W'(ACTIONS);
	assign idx_c  = base_c + ADDR_W'(act_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = idx_q;
		ram_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			S_ROW:   ram_addr = base_q + ADDR_W'(cnt_q);
			S_CUR:   ram_addr = ADDR_W'(held_entry_q);
			S_WRITE: begin
				ram_we    = 1'b1;
				ram_addr  = ADDR_W'(held_entry_q);
				ram_wdata = alu_result;
			end
			default: ;
		endcase
	end

	always_comb begin
		alu_ctrl.en = 1'b1;
		alu_ctrl.op = ALU_MUL_GAMMA;
		unique case (state_q)
			S_CUR_W: alu_ctrl.op = ALU_MUL_GAMMA;
			S_SUM:   alu_ctrl.op = ALU_SUM;
			S_MUL_A: alu_ctrl.op = ALU_MUL_ALPHA;
			S_FINAL: alu_ctrl.op = ALU_FINAL;
			default: alu_ctrl.en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			held_entry_q  <= '0;
			held_reward_q <= '0;
			row_rd_s1     <= 1'b0;
			first_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			row_rd_s1 <= (state_q == S_ROW);
			if (row_rd_s1 && (first_q || $signed(ram_rdata) > best_q)) begin
				best_q  <= $signed(ram_rdata);
				first_q <= 1'b0;
			end
			if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(TABLE_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && item_ok) begin
						s_q     <= state_of(req.hp, req.scrap, req.power, req.fuel,
							req.stage, req.bomb);
						enc_q   <= req.encounter;
						act_q   <= req.action;
						cmd_q   <= cmd_t'(req.command);
						rwd_q   <= req.reward;
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					unique case (cmd_q)
						CMD_LATCH: begin
							held_entry_q  <= INDEX_W'(idx_c);
							held_reward_q <= rwd_q;
							state_q       <= S_IDLE;
						end
						CMD_READ: begin
							idx_q   <= idx_c;
							state_q <= S_READ;
						end
						CMD_UPDATE: begin
							base_q  <= base_c;
							cnt_q   <= '0;
							first_q <= 1'b1;
							if (32'(held_entry_q) >= 32'(TABLE_SIZE)) begin
								state_q <= S_IDLE;
							end else begin
								state_q <= S_ROW;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_ROW: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ACT_W'(ACTIONS - 1)) begin
						state_q <= S_CUR;
					end
				end
				S_CUR: state_q <= S_CUR_W;
				S_CUR_W: begin
					cur_q   <= $signed(ram_rdata);
					state_q <= S_SUM;
				end
				S_SUM:   state_q <= S_MUL_A;
				S_MUL_A: state_q <= S_FINAL;
				S_FINAL: state_q <= S_WRITE;
				S_WRITE: begin
					res_val_q <= alu_result;
					res_idx_q <= held_entry_q;
					state_q   <= S_DONE;
				end
				S_READ: state_q <= S_READ_W;
				S_READ_W: begin
					res_val_q <= $signed(ram_rdata);
					res_idx_q <= INDEX_W'(idx_q);
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_val_q   <= res_val_q;
						out_idx_q   <= res_idx_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.q_value     = out_val_q;
	assign rsp.entry_index = out_idx_q;

	qlu_ram #(
		.WIDTH (Q_W),
		.DEPTH (TABLE_SIZE)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	qlu_alu u_alu (
		.clk    (clk),
		.ctrl   (alu_ctrl),
		.alpha  (alpha_q),
		.gamma  (gamma_q),
		.best   (best_q),
		.cur    (cur_q),
		.reward (held_reward_q),
		.result (alu_result)
	);

endmodule

`default_nettype wire
